// ----- src/akf_pkg.sv -----
// Shared constants, micro-op table and types for the altitude Kalman filter core.
package akf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_FRAC = 24;
    localparam int DIV_W     = 32 + GAIN_FRAC;
    localparam int DCNT_W    = $clog2(DIV_W + 1);
    localparam int WIDE_W    = 68;

    localparam logic signed [31:0] ONE_FX    = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] SPEED_LIM = 32'((64'sd2401 <<< FRAC_BITS) / 10);
    localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

    localparam logic [1:0] CMD_PREDICT = 2'd0;
    localparam logic [1:0] CMD_UPDATE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] CFG_INIT_ALT = 2'd0;
    localparam logic [1:0] CFG_PROC_NZ  = 2'd1;
    localparam logic [1:0] CFG_MEAS_NZ  = 2'd2;

    // multiplier operand A
    localparam logic [3:0] A_DT = 4'd0, A_ACCEL = 4'd1, A_VEL = 4'd2, A_CV = 4'd3,
                           A_T = 4'd4, A_CC = 4'd5, A_PN = 4'd6, A_ALT = 4'd7,
                           A_MN = 4'd8, A_K0 = 4'd9, A_K1 = 4'd10;
    // multiplier operand B
    localparam logic [2:0] B_DT = 3'd0, B_DT2 = 3'd1, B_TWO_DT = 3'd2, B_ONE = 3'd3,
                           B_Y = 3'd4, B_CP = 3'd5, B_CC = 3'd6;
    // base to which the rounded product is added, or from which it is subtracted
    localparam logic [2:0] BS_ZERO = 3'd0, BS_ALT = 3'd1, BS_VEL = 3'd2, BS_CP = 3'd3,
                           BS_CC = 3'd4, BS_CV = 3'd5, BS_ACC = 3'd6, BS_BARO = 3'd7;
    // rounding shift
    localparam logic [1:0] SH_0 = 2'd0, SH_16 = 2'd1, SH_24 = 2'd2, SH_33 = 2'd3;
    // destination
    localparam logic [3:0] D_DT2 = 4'd0, D_NA = 4'd1, D_NV = 4'd2, D_NP = 4'd3,
                           D_NC = 4'd4, D_NQ = 4'd5, D_ACC = 4'd6, D_T = 4'd7,
                           D_Y = 4'd8, D_S = 4'd9, D_K0 = 4'd10, D_K1 = 4'd11;

    localparam logic [4:0] STEP_PREDICT = 5'd0;
    localparam logic [4:0] STEP_UPDATE  = 5'd16;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] base_sel;
        logic       neg;
        logic       pre_acc;
        logic [1:0] shift;
        logic [3:0] dest;
        logic       is_div;
        logic       last;
    } t_uop;

    function automatic t_uop mk(input logic [3:0] a, input logic [2:0] b,
                                input logic [2:0] bs, input logic ng, input logic pa,
                                input logic [1:0] sh, input logic [3:0] d,
                                input logic dv, input logic ls);
        t_uop u;
        u.a_sel = a; u.b_sel = b; u.base_sel = bs; u.neg = ng; u.pre_acc = pa;
        u.shift = sh; u.dest = d; u.is_div = dv; u.last = ls;
        return u;
    endfunction

    function automatic t_uop uop_of(input logic [4:0] step);
        t_uop u;
        unique case (step)
            5'd0:  u = mk(A_DT,    B_DT,     BS_ZERO, 1'b0, 1'b0, SH_0,  D_DT2, 1'b0, 1'b0);
            5'd1:  u = mk(A_ACCEL, B_DT,     BS_VEL,  1'b0, 1'b0, SH_16, D_NV,  1'b0, 1'b0);
            5'd2:  u = mk(A_VEL,   B_DT,     BS_ALT,  1'b0, 1'b0, SH_16, D_ACC, 1'b0, 1'b0);
            5'd3:  u = mk(A_ACCEL, B_DT2,    BS_ACC,  1'b0, 1'b0, SH_33, D_NA,  1'b0, 1'b0);
            5'd4:  u = mk(A_CV,    B_DT,     BS_ZERO, 1'b0, 1'b0, SH_16, D_T,   1'b0, 1'b0);
            5'd5:  u = mk(A_T,     B_ONE,    BS_CC,   1'b0, 1'b0, SH_0,  D_NC,  1'b0, 1'b0);
            5'd6:  u = mk(A_CC,    B_TWO_DT, BS_ZERO, 1'b0, 1'b0, SH_0,  D_ACC, 1'b0, 1'b0);
            5'd7:  u = mk(A_T,     B_DT,     BS_CP,   1'b0, 1'b1, SH_16, D_NP,  1'b0, 1'b0);
            5'd8:  u = mk(A_PN,    B_DT,     BS_CV,   1'b0, 1'b0, SH_16, D_NQ,  1'b0, 1'b1);
            5'd16: u = mk(A_ALT,   B_ONE,    BS_BARO, 1'b1, 1'b0, SH_0,  D_Y,   1'b0, 1'b0);
            5'd17: u = mk(A_MN,    B_ONE,    BS_CP,   1'b0, 1'b0, SH_0,  D_S,   1'b0, 1'b0);
            5'd18: u = mk(A_DT,    B_DT,     BS_ZERO, 1'b0, 1'b0, SH_0,  D_K0,  1'b1, 1'b0);
            5'd19: u = mk(A_DT,    B_DT,     BS_ZERO, 1'b0, 1'b0, SH_0,  D_K1,  1'b1, 1'b0);
            5'd20: u = mk(A_K0,    B_Y,      BS_ALT,  1'b0, 1'b0, SH_24, D_NA,  1'b0, 1'b0);
            5'd21: u = mk(A_K1,    B_Y,      BS_VEL,  1'b0, 1'b0, SH_24, D_NV,  1'b0, 1'b0);
            5'd22: u = mk(A_K0,    B_CP,     BS_CP,   1'b1, 1'b0, SH_24, D_NP,  1'b0, 1'b0);
            5'd23: u = mk(A_K0,    B_CC,     BS_CC,   1'b1, 1'b0, SH_24, D_NC,  1'b0, 1'b0);
            5'd24: u = mk(A_K1,    B_CC,     BS_CV,   1'b1, 1'b0, SH_24, D_NQ,  1'b0, 1'b1);
            default: u = mk(A_DT,  B_DT,     BS_ZERO, 1'b0, 1'b0, SH_0,  D_ACC, 1'b0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// ----- src/akf_div.sv -----
// Serial restoring divider: (num * 2^GAIN_FRAC) / den, truncated, clipped to 32 bits.
module akf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic        [31:0]  i_den,
    output logic                o_done,
    output logic signed [31:0]  o_quo
);
    import akf_pkg::*;

    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_quo;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_neg;
    logic              r_done;

    logic [32:0] trial;
    logic        fits;
    logic [31:0] mag;

    assign mag   = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign trial = {r_rem, r_num[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {mag, {GAIN_FRAC{1'b0}}};
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_quo > DIV_W'(64'h8000_0000)) o_quo = S32_MIN;
            else                               o_quo = 32'(-r_quo);
        end else begin
            if (r_quo > DIV_W'(64'h7FFF_FFFF)) o_quo = S32_MAX;
            else                               o_quo = 32'(r_quo);
        end
    end

    assign o_done = r_done;

endmodule

// ----- src/altitude_kalman_filter_core.sv -----
// Altitude/velocity Kalman filter core on one shared multiplier and a serial divider.
//
// Input channel i_valid/o_ready carries one request: i_cmd (predict, update, restart)
// with i_accel, i_time_step and i_baro_altitude. Each request yields exactly one
// result on o_valid/i_ready: the altitude and velocity after the step plus the
// update_skipped and saturated flags.
// One request is processed at a time; o_ready is high only while the sequencer idles.
// Predict runs 9 multiply/accumulate ops (multiply, then finish) plus commit and output.
// Update runs 2 setup ops, two gain divisions on the serial divider (one quotient bit
// per cycle) and 5 ops, then commit and output.
// Restart, a skipped update and the unused command go straight to output.
// Configuration writes on i_cfg_we land at once; init_altitude takes effect on restart.
// Reset loads the default registers and the restart state (altitude 0, unit covariance).
// A result waits in the output register while i_ready is low; the next request is
// still taken and computed, then held in the core until the output register frees.
module altitude_kalman_filter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_accel,
    input  logic [15:0]        i_time_step,
    input  logic signed [31:0] i_baro_altitude,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_altitude_est,
    output logic signed [31:0] o_velocity_est,
    output logic               o_update_skipped,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import akf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_MUL = 3'd1, ST_FIN = 3'd2, ST_DIVI = 3'd3,
                           ST_DIV = 3'd4, ST_COMMIT = 3'd5, ST_OUT = 3'd6;

    typedef logic signed [WIDE_W-1:0] t_wide;

    logic [2:0] r_state;
    logic [4:0] r_step;

    logic signed [31:0] r_init;
    logic [30:0]        r_pn, r_mn;
    logic signed [31:0] r_alt, r_vel, r_cp, r_cc, r_cv;
    logic signed [31:0] r_na, r_nv, r_np, r_nc, r_nq;
    logic signed [31:0] r_accel, r_baro, r_y, r_k0, r_k1;
    logic [15:0]        r_dt;
    logic [31:0]        r_dt2, r_s;
    logic signed [32:0] r_t;
    t_wide              r_acc;
    logic signed [65:0] r_prod;
    logic               r_skip, r_sat;

    logic               r_o_valid;
    logic signed [31:0] r_o_alt, r_o_vel;
    logic               r_o_skip, r_o_sat;

    t_uop               uop, uop_nx;
    logic signed [32:0] mul_a, mul_b;
    t_wide              x, rv, base, v;
    logic signed [31:0] vclip;
    logic               vov;
    logic               div_start, div_done;
    logic signed [31:0] div_quo;
    logic               out_free;

    assign uop    = uop_of(r_step);
    assign uop_nx = uop_of(r_step + 5'd1);

    always_comb begin
        unique case (uop.a_sel)
            A_DT:    mul_a = 33'(r_dt);
            A_ACCEL: mul_a = 33'(r_accel);
            A_VEL:   mul_a = 33'(r_vel);
            A_CV:    mul_a = 33'(r_cv);
            A_T:     mul_a = r_t;
            A_CC:    mul_a = 33'(r_cc);
            A_PN:    mul_a = 33'(r_pn);
            A_ALT:   mul_a = 33'(r_alt);
            A_MN:    mul_a = 33'(r_mn);
            A_K0:    mul_a = 33'(r_k0);
            A_K1:    mul_a = 33'(r_k1);
            default: mul_a = '0;
        endcase
        unique case (uop.b_sel)
            B_DT:     mul_b = 33'(r_dt);
            B_DT2:    mul_b = 33'(r_dt2);
            B_TWO_DT: mul_b = 33'({r_dt, 1'b0});
            B_ONE:    mul_b = 33'sd1;
            B_Y:      mul_b = 33'(r_y);
            B_CP:     mul_b = 33'(r_cp);
            B_CC:     mul_b = 33'(r_cc);
            default:  mul_b = '0;
        endcase
    end

    // finish: base +/- round(product [+ acc]), then clip to 32 bits
    always_comb begin
        x = WIDE_W'(r_prod) + (uop.pre_acc ? r_acc : t_wide'(0));
        unique case (uop.shift)
            SH_0:    rv = x;
            SH_16:   rv = (x + (t_wide'(1) <<< 15)) >>> 16;
            SH_24:   rv = (x + (t_wide'(1) <<< 23)) >>> 24;
            default: rv = (x + (t_wide'(1) <<< 32)) >>> 33;
        endcase
        unique case (uop.base_sel)
            BS_ZERO: base = '0;
            BS_ALT:  base = WIDE_W'(r_alt);
            BS_VEL:  base = WIDE_W'(r_vel);
            BS_CP:   base = WIDE_W'(r_cp);
            BS_CC:   base = WIDE_W'(r_cc);
            BS_CV:   base = WIDE_W'(r_cv);
            BS_ACC:  base = r_acc;
            default: base = WIDE_W'(r_baro);
        endcase
        v = uop.neg ? base - rv : base + rv;
        if (v > WIDE_W'(S32_MAX)) begin
            vclip = S32_MAX; vov = 1'b1;
        end else if (v < WIDE_W'(S32_MIN)) begin
            vclip = S32_MIN; vov = 1'b1;
        end else begin
            vclip = 32'(v);  vov = 1'b0;
        end
    end

    assign div_start = (r_state == ST_DIVI);

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ((uop.dest == D_K0) ? r_cp : r_cc),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_init  <= '0;
            r_pn    <= 31'd655;
            r_mn    <= 31'd65536;
            r_alt   <= '0;
            r_vel   <= '0;
            r_cp    <= ONE_FX;
            r_cc    <= '0;
            r_cv    <= ONE_FX;
            r_skip  <= 1'b0;
            r_sat   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INIT_ALT: r_init <= i_cfg_data;
                    CFG_PROC_NZ:  r_pn   <= i_cfg_data[30:0];
                    CFG_MEAS_NZ:  r_mn   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && out_free) r_o_valid <= 1'b1;
            else if (r_o_valid && i_ready)     r_o_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_skip <= 1'b0;
                        r_sat  <= 1'b0;
                        unique case (i_cmd)
                            CMD_PREDICT: begin
                                r_step  <= STEP_PREDICT;
                                r_state <= ST_MUL;
                            end
                            CMD_UPDATE: begin
                                if (r_vel > SPEED_LIM || r_vel < -SPEED_LIM) begin
                                    r_skip  <= 1'b1;
                                    r_state <= ST_OUT;
                                end else begin
                                    r_step  <= STEP_UPDATE;
                                    r_state <= ST_MUL;
                                end
                            end
                            CMD_RESTART: begin
                                r_alt   <= r_init;
                                r_vel   <= '0;
                                r_cp    <= ONE_FX;
                                r_cc    <= '0;
                                r_cv    <= ONE_FX;
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_MUL: r_state <= ST_FIN;
                ST_FIN, ST_DIV: begin
                    if (r_state == ST_FIN || div_done) begin
                        if (uop.last) begin
                            r_state <= ST_COMMIT;
                        end else begin
                            r_step  <= r_step + 5'd1;
                            r_state <= uop_nx.is_div ? ST_DIVI : ST_MUL;
                        end
                        if (r_state == ST_FIN && vov &&
                            (uop.dest == D_NA || uop.dest == D_NV || uop.dest == D_NP ||
                             uop.dest == D_NC || uop.dest == D_NQ))
                            r_sat <= 1'b1;
                    end
                end
                ST_DIVI: r_state <= ST_DIV;
                ST_COMMIT: begin
                    r_alt   <= r_na;
                    r_vel   <= r_nv;
                    r_cp    <= r_np;
                    r_cc    <= r_nc;
                    r_cv    <= r_nq;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_accel <= i_accel;
            r_dt    <= i_time_step;
            r_baro  <= i_baro_altitude;
        end
        if (r_state == ST_MUL) r_prod <= mul_a * mul_b;
        if (r_state == ST_FIN) begin
            unique case (uop.dest)
                D_DT2: r_dt2 <= v[31:0];
                D_NA:  r_na  <= vclip;
                D_NV:  r_nv  <= vclip;
                D_NP:  r_np  <= vclip;
                D_NC:  r_nc  <= vclip;
                D_NQ:  r_nq  <= vclip;
                D_ACC: r_acc <= v;
                D_T:   r_t   <= v[32:0];
                D_Y:   r_y   <= vclip;
                D_S:   r_s   <= (v < t_wide'(1)) ? 32'd1 : v[31:0];
                default: ;
            endcase
        end
        if (r_state == ST_DIV && div_done) begin
            if (uop.dest == D_K0) r_k0 <= div_quo;
            else                  r_k1 <= div_quo;
        end
        if (r_state == ST_OUT && out_free) begin
            r_o_alt  <= r_alt;
            r_o_vel  <= r_vel;
            r_o_skip <= r_skip;
            r_o_sat  <= r_sat;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_altitude_est   = r_o_alt;
    assign o_velocity_est   = r_o_vel;
    assign o_update_skipped = r_o_skip;
    assign o_saturated      = r_o_sat;

    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVI) |-> (r_s != 32'd0))
        else $error("divider started with zero denominator");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("core ready right after accepting a request");

    a_skip_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_update_skipped) |-> !o_saturated)
        else $error("skipped update reported saturation");

    a_step_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_step <= 5'd8 || (r_step >= STEP_UPDATE && r_step <= 5'd24)))
        else $error("sequencer step outside microprogram");

endmodule
